// ===== rtl/core/fm_voice_allocator_assert.svh =====
// Assertion macros for the FM voice allocator.
`ifndef FM_VOICE_ALLOCATOR_ASSERT_SVH
`define FM_VOICE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, held off while reset is asserted.
`define FMVA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define FMVA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/fmva_pkg.sv =====
// Shared constants, command/status types and helpers for the FM voice allocator.
package fmva_pkg;

  // Parameter defaults
  localparam int NUM_VOICES_DEF            = 18;
  localparam int NUM_CHANNELS_DEF          = 16;
  localparam int MAX_NOTES_PER_CHANNEL_DEF = 99;
  localparam int AGE_BITS_DEF              = 22;

  // Input function codes
  localparam logic [2:0] FN_NOTE_ON   = 3'd0;
  localparam logic [2:0] FN_NOTE_OFF  = 3'd1;
  localparam logic [2:0] FN_PROGRAM   = 3'd2;
  localparam logic [2:0] FN_VOLUME    = 3'd3;
  localparam logic [2:0] FN_ALL_OFF   = 3'd4;
  localparam logic [2:0] FN_ADVANCE   = 3'd5;

  // Result action codes
  localparam logic [1:0] ACT_KEY_OFF  = 2'd0;
  localparam logic [1:0] ACT_KEY_ON   = 2'd1;
  localparam logic [1:0] ACT_LEVEL    = 2'd2;

  // Percussion mapping
  localparam logic [3:0] PERC_CH      = 4'd9;
  localparam logic [6:0] PERC_KEY_LO  = 7'd35;
  localparam logic [6:0] PERC_KEY_HI  = 7'd87;
  localparam logic [7:0] PERC_INS_OFS = 8'd93;

  // Scoring weights
  localparam int SCORE_FREE  = 3000000;
  localparam int SCORE_SAME  = 200;
  localparam int SCORE_PERC  = 9000;

  // Datapath commands
  localparam logic [3:0] CMD_NONE      = 4'd0;
  localparam logic [3:0] CMD_LATCH     = 4'd1;
  localparam logic [3:0] CMD_CLEAR     = 4'd2;
  localparam logic [3:0] CMD_ADVANCE   = 4'd3;
  localparam logic [3:0] CMD_PATCH     = 4'd4;
  localparam logic [3:0] CMD_VOLUME    = 4'd5;
  localparam logic [3:0] CMD_MASK      = 4'd6;
  localparam logic [3:0] CMD_MAP_RD    = 4'd7;
  localparam logic [3:0] CMD_MAP_HIT   = 4'd8;
  localparam logic [3:0] CMD_SCAN_INIT = 4'd9;
  localparam logic [3:0] CMD_SCAN_STEP = 4'd10;
  localparam logic [3:0] CMD_SEL_WIN   = 4'd11;
  localparam logic [3:0] CMD_RELEASE   = 4'd12;
  localparam logic [3:0] CMD_KEYON     = 4'd13;
  localparam logic [3:0] CMD_WALK_PICK = 4'd14;
  localparam logic [3:0] CMD_LEVEL     = 4'd15;

  typedef struct packed {
    logic [3:0] op;
    logic       last;
  } fmva_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       ch_ok;
    logic       val_zero;
    logic       perc_ok;
    logic       map_valid;
    logic       map_hit;
    logic       scan_last;
    logic       drop;
    logic       cur_busy;
    logic       mask_empty;
    logic       walk_last;
    logic       out_free;
    logic       clr_last;
  } fmva_sts_t;

  // vel*vol/127: quotient estimate by a shift, then one correction step
  function automatic logic [6:0] level_of(input logic [6:0] vel, input logic [6:0] vol);
    logic [13:0] p;
    logic [6:0]  q0;
    logic [7:0]  r;
    p  = vel * vol;
    q0 = p[13:7];
    r  = {1'b0, p[6:0]} + {1'b0, q0};
    level_of = (r >= 8'd127) ? q0 + 7'd1 : q0;
  endfunction

endpackage

// ===== rtl/core/fmva_if.sv =====
// Valid/ready channel interfaces for MIDI events and voice actions.
interface fmva_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [3:0] midi_channel;
  logic [6:0] key_or_program;
  logic [6:0] value;
  logic [15:0] elapsed_ms;

  modport source (output valid, func, midi_channel, key_or_program, value, elapsed_ms,
                  input ready);
  modport sink   (input valid, func, midi_channel, key_or_program, value, elapsed_ms,
                  output ready);
endinterface

interface fmva_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [4:0] voice;
  logic [7:0] instrument;
  logic [6:0] note_key;
  logic [6:0] level;
  logic       last;

  modport source (output valid, action, voice, instrument, note_key, level, last,
                  input ready);
  modport sink   (input valid, action, voice, instrument, note_key, level, last,
                  output ready);
endinterface

// ===== rtl/core/fmva_ctrl.sv =====
// Sequencing state machine for the FM voice allocator.
module fmva_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fmva_pkg::fmva_sts_t sts_i,
  output fmva_pkg::fmva_cmd_t cmd_o
);
  import fmva_pkg::*;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DISP   = 4'd2;
  localparam logic [3:0] S_MAPCHK = 4'd3;
  localparam logic [3:0] S_SCAN   = 4'd4;
  localparam logic [3:0] S_SELWIN = 4'd5;
  localparam logic [3:0] S_CHECK  = 4'd6;
  localparam logic [3:0] S_STEAL  = 4'd7;
  localparam logic [3:0] S_KEYON  = 4'd8;
  localparam logic [3:0] S_NOFF   = 4'd9;
  localparam logic [3:0] S_WPICK  = 4'd10;
  localparam logic [3:0] S_WEMIT  = 4'd11;

  logic [3:0] state_q, state_d;
  logic       is_off;

  assign in_ready_o = (state_q == S_IDLE);
  // note-on with zero velocity behaves as note-off
  assign is_off = (sts_i.func == FN_NOTE_OFF) || sts_i.val_zero;

  // Next state and command
  always_comb begin
    state_d   = state_q;
    cmd_o.op  = CMD_NONE;
    cmd_o.last = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.op = CMD_CLEAR;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = CMD_LATCH;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_IDLE;
        if (sts_i.func == FN_ADVANCE) begin
          cmd_o.op = CMD_ADVANCE;
        end else if (sts_i.ch_ok) begin
          case (sts_i.func)
            FN_PROGRAM: cmd_o.op = CMD_PATCH;
            FN_VOLUME: begin
              cmd_o.op = CMD_VOLUME;
              state_d  = S_WPICK;
            end
            FN_ALL_OFF: begin
              cmd_o.op = CMD_MASK;
              state_d  = S_WPICK;
            end
            FN_NOTE_ON, FN_NOTE_OFF: begin
              if (is_off || sts_i.perc_ok) begin
                cmd_o.op = CMD_MAP_RD;
                state_d  = S_MAPCHK;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_MAPCHK: begin
        state_d = S_IDLE;
        if (is_off) begin
          if (sts_i.map_hit) begin
            cmd_o.op = CMD_MAP_HIT;
            state_d  = S_NOFF;
          end
        end else if (!sts_i.map_valid) begin
          cmd_o.op = CMD_SCAN_INIT;
          state_d  = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.op = CMD_SCAN_STEP;
        if (sts_i.scan_last) state_d = S_SELWIN;
      end
      S_SELWIN: begin
        cmd_o.op = CMD_SEL_WIN;
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.drop)          state_d = S_IDLE;
        else if (sts_i.cur_busy) state_d = S_STEAL;
        else                     state_d = S_KEYON;
      end
      S_STEAL: begin
        if (sts_i.out_free) begin
          cmd_o.op = CMD_RELEASE;
          state_d  = S_KEYON;
        end
      end
      S_KEYON: begin
        if (sts_i.out_free) begin
          cmd_o.op   = CMD_KEYON;
          cmd_o.last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_NOFF: begin
        if (sts_i.out_free) begin
          cmd_o.op   = CMD_RELEASE;
          cmd_o.last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_WPICK: begin
        if (sts_i.mask_empty) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.op = CMD_WALK_PICK;
          state_d  = S_WEMIT;
        end
      end
      S_WEMIT: begin
        if (sts_i.out_free) begin
          cmd_o.op   = (sts_i.func == FN_VOLUME) ? CMD_LEVEL : CMD_RELEASE;
          cmd_o.last = sts_i.walk_last;
          state_d    = S_WPICK;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else         state_q <= state_d;
  end

endmodule

// ===== rtl/core/fmva_dp.sv =====
// Voice, channel and note-map storage with scoring, walk and output register.
module fmva_dp #(
  parameter int NUM_VOICES            = fmva_pkg::NUM_VOICES_DEF,
  parameter int NUM_CHANNELS          = fmva_pkg::NUM_CHANNELS_DEF,
  parameter int MAX_NOTES_PER_CHANNEL = fmva_pkg::MAX_NOTES_PER_CHANNEL_DEF,
  parameter int AGE_BITS              = fmva_pkg::AGE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fmva_pkg::fmva_cmd_t cmd_i,
  output fmva_pkg::fmva_sts_t sts_o,
  input  logic [2:0]          func_i,
  input  logic [3:0]          midi_channel_i,
  input  logic [6:0]          key_or_program_i,
  input  logic [6:0]          value_i,
  input  logic [15:0]         elapsed_ms_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          action_o,
  output logic [4:0]          voice_o,
  output logic [7:0]          instrument_o,
  output logic [6:0]          note_key_o,
  output logic [6:0]          level_o,
  output logic                last_o
);
  import fmva_pkg::*;

  localparam int VW  = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int CW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int MD  = NUM_CHANNELS * 128;
  localparam int MAW = $clog2(MD);
  localparam int SW  = ((AGE_BITS > 22) ? AGE_BITS : 22) + 3;
  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  // Latched event
  logic [2:0]  func_q;
  logic [3:0]  ch_q;
  logic [6:0]  key_q, val_q;
  logic [15:0] dt_q;

  // Voice state
  logic                busy_q  [NUM_VOICES];
  logic [7:0]          vins_q  [NUM_VOICES];
  logic [AGE_BITS-1:0] age_q   [NUM_VOICES];
  logic [3:0]          och_q   [NUM_VOICES];
  logic [6:0]          okey_q  [NUM_VOICES];
  logic [6:0]          vel_q   [NUM_VOICES];

  // Channel state
  logic [6:0] patch_q [NUM_CHANNELS];
  logic [6:0] vol_q   [NUM_CHANNELS];
  logic [6:0] cnt_q   [NUM_CHANNELS];

  // Note map memory
  logic [5:0]     map_mem [MD];
  logic [5:0]     map_rd_q;
  logic [MAW-1:0] clr_q;
  logic           map_we;
  logic [MAW-1:0] map_wa;
  logic [5:0]     map_wd;

  // Walk / scan control
  logic [VW-1:0]         cur_q, win_q;
  logic [SW-1:0]         best_q;
  logic [NUM_VOICES-1:0] mask_q, match;
  logic                  walk_last_q;
  logic [VW-1:0]         low_idx;

  logic [CW-1:0]  ch_idx, rel_idx, cnt_idx;
  logic [MAW-1:0] item_addr;
  logic [7:0]     ins;
  logic [SW-1:0]  score, s0;
  logic [6:0]     cnt_rd, cnt_adj;
  logic           out_free, emit;
  logic           is_release, is_keyon, is_level;

  assign ch_idx    = ch_q[CW-1:0];
  assign rel_idx   = och_q[cur_q][CW-1:0];
  assign item_addr = MAW'({ch_q[CW-1:0], key_q});
  assign ins       = (ch_q == PERC_CH) ? 8'(key_q) + PERC_INS_OFS : {1'b0, patch_q[ch_idx]};

  assign is_release = (cmd_i.op == CMD_RELEASE);
  assign is_keyon   = (cmd_i.op == CMD_KEYON);
  assign is_level   = (cmd_i.op == CMD_LEVEL);
  assign emit       = is_release || is_keyon || is_level;
  assign out_free   = !out_valid_o || out_ready_i;

  // Latch event fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == CMD_LATCH) begin
      func_q <= func_i;
      ch_q   <= midi_channel_i;
      key_q  <= key_or_program_i;
      val_q  <= value_i;
      dt_q   <= elapsed_ms_i;
    end
  end

  // Owner match over all voices
  always_comb begin
    for (int v = 0; v < NUM_VOICES; v++) begin
      match[v] = busy_q[v] && (och_q[v] == ch_q);
    end
  end

  // Lowest pending voice of the walk
  always_comb begin
    low_idx = '0;
    for (int v = NUM_VOICES - 1; v >= 0; v--) begin
      if (mask_q[v]) low_idx = VW'(v);
    end
  end

  // Score of the voice under the scan pointer
  always_comb begin
    s0 = SW'(age_q[cur_q]) + (busy_q[cur_q] ? '0 : SW'(SCORE_FREE))
       + ((vins_q[cur_q] == ins) ? SW'(SCORE_SAME) : '0);
    if (!ins[7] && vins_q[cur_q][7]) score = {s0[SW-2:0], 1'b0} + SW'(SCORE_PERC);
    else                             score = s0;
  end

  // Channel note count read, at the released voice's owner or the event channel
  assign cnt_idx = is_release ? rel_idx : ch_idx;
  assign cnt_rd  = cnt_q[cnt_idx];
  always_comb begin
    cnt_adj = cnt_rd;
    if (busy_q[cur_q] && (och_q[cur_q] == ch_q) && (cnt_rd != 7'd0)) cnt_adj = cnt_rd - 7'd1;
  end

  // Scan, walk and pointer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      win_q       <= '0;
      best_q      <= '0;
      mask_q      <= '0;
      walk_last_q <= 1'b0;
    end else begin
      case (cmd_i.op)
        CMD_MAP_HIT:   cur_q <= map_rd_q[VW-1:0];
        CMD_SCAN_INIT: cur_q <= '0;
        CMD_SCAN_STEP: begin
          if ((cur_q == '0) || (score > best_q)) begin
            best_q <= score;
            win_q  <= cur_q;
          end
          cur_q <= cur_q + VW'(1);
        end
        CMD_SEL_WIN: cur_q <= win_q;
        CMD_VOLUME, CMD_MASK: mask_q <= match;
        CMD_WALK_PICK: begin
          cur_q          <= low_idx;
          mask_q[low_idx] <= 1'b0;
          walk_last_q    <= ((mask_q & (mask_q - NUM_VOICES'(1))) == '0);
        end
        default: ;
      endcase
    end
  end

  // Voice state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < NUM_VOICES; v++) begin
        busy_q[v] <= 1'b0;
        vins_q[v] <= '0;
        age_q[v]  <= '0;
        och_q[v]  <= '0;
        okey_q[v] <= '0;
      end
    end else begin
      case (cmd_i.op)
        CMD_ADVANCE: begin
          for (int v = 0; v < NUM_VOICES; v++) begin
            logic [AGE_BITS:0] sum;
            sum = {1'b0, age_q[v]} + (AGE_BITS + 1)'(dt_q);
            age_q[v] <= sum[AGE_BITS] ? AGE_MAX : sum[AGE_BITS-1:0];
          end
        end
        CMD_RELEASE: begin
          busy_q[cur_q] <= 1'b0;
          age_q[cur_q]  <= '0;
        end
        CMD_KEYON: begin
          busy_q[cur_q] <= 1'b1;
          vins_q[cur_q] <= ins;
          age_q[cur_q]  <= '0;
          och_q[cur_q]  <= ch_q;
          okey_q[cur_q] <= key_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_keyon) vel_q[cur_q] <= val_q;
  end

  // Channel state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        patch_q[c] <= '0;
        vol_q[c]   <= 7'd127;
        cnt_q[c]   <= '0;
      end
    end else begin
      case (cmd_i.op)
        CMD_PATCH:   patch_q[ch_idx] <= key_q;
        CMD_VOLUME:  vol_q[ch_idx]   <= val_q;
        CMD_KEYON:   cnt_q[ch_idx]   <= cnt_rd + 7'd1;
        CMD_RELEASE: if (cnt_rd != 7'd0) cnt_q[rel_idx] <= cnt_rd - 7'd1;
        default: ;
      endcase
    end
  end

  // Note map write port
  always_comb begin
    map_we = 1'b0;
    map_wa = item_addr;
    map_wd = '0;
    case (cmd_i.op)
      CMD_CLEAR: begin
        map_we = 1'b1;
        map_wa = clr_q;
      end
      CMD_RELEASE: begin
        map_we = 1'b1;
        map_wa = MAW'({och_q[cur_q][CW-1:0], okey_q[cur_q]});
      end
      CMD_KEYON: begin
        map_we = 1'b1;
        map_wd = {1'b1, 5'(cur_q)};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    if (cmd_i.op == CMD_MAP_RD) map_rd_q <= map_mem[item_addr];
  end

  // Clearing pass counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.op == CMD_CLEAR) clr_q <= clr_q + MAW'(1);
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (emit) out_valid_o <= 1'b1;
    else if (out_ready_i) out_valid_o <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      voice_o <= 5'(cur_q);
      last_o  <= cmd_i.last;
      if (is_keyon) begin
        action_o     <= ACT_KEY_ON;
        instrument_o <= ins;
        note_key_o   <= key_q;
        level_o      <= level_of(val_q, vol_q[ch_idx]);
      end else if (is_level) begin
        action_o     <= ACT_LEVEL;
        instrument_o <= vins_q[cur_q];
        note_key_o   <= okey_q[cur_q];
        level_o      <= level_of(vel_q[cur_q], val_q);
      end else begin
        action_o     <= ACT_KEY_OFF;
        instrument_o <= vins_q[cur_q];
        note_key_o   <= okey_q[cur_q];
        level_o      <= '0;
      end
    end
  end

  // Status to the controller
  assign sts_o.func       = func_q;
  assign sts_o.ch_ok      = ({1'b0, ch_q} < 5'(NUM_CHANNELS));
  assign sts_o.val_zero   = (val_q == 7'd0);
  assign sts_o.perc_ok    = (ch_q != PERC_CH) ||
                            ((key_q >= PERC_KEY_LO) && (key_q <= PERC_KEY_HI));
  assign sts_o.map_valid  = map_rd_q[5];
  assign sts_o.map_hit    = map_rd_q[5] && ({1'b0, map_rd_q[4:0]} < 6'(NUM_VOICES));
  assign sts_o.scan_last  = (cur_q == VW'(NUM_VOICES - 1));
  assign sts_o.drop       = (cnt_adj >= 7'(MAX_NOTES_PER_CHANNEL));
  assign sts_o.cur_busy   = busy_q[cur_q];
  assign sts_o.mask_empty = (mask_q == '0);
  assign sts_o.walk_last  = walk_last_q;
  assign sts_o.out_free   = out_free;
  assign sts_o.clr_last   = (clr_q == '1);

endmodule

// ===== rtl/core/fm_voice_allocator.sv =====
// Top level of the FM voice allocator: controller, datapath and checks.
//
//  channel | dir | beat contents
//  in_i    | in  | func, midi_channel, key_or_program, value, elapsed_ms
//  out_o   | out | action, voice, instrument, note_key, level, last
//
// After reset all NUM_CHANNELS*128 note-map entries (2048 by default) are
// cleared before the first event is taken.
// An event is taken only when the previous one is finished. A note-on
// scans every voice (one voice scored per cycle) before its key-on;
// volume and all-notes-off emit one result beat per matching voice.
// Result beats wait in an output register; a stalled sink holds the
// sequencer at its next result.
module fm_voice_allocator #(
  parameter int NUM_VOICES            = fmva_pkg::NUM_VOICES_DEF,
  parameter int NUM_CHANNELS          = fmva_pkg::NUM_CHANNELS_DEF,
  parameter int MAX_NOTES_PER_CHANNEL = fmva_pkg::MAX_NOTES_PER_CHANNEL_DEF,
  parameter int AGE_BITS              = fmva_pkg::AGE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fmva_in_if.sink    in_i,
  fmva_out_if.source out_o
);
  import fmva_pkg::*;

`include "fm_voice_allocator_assert.svh"

  fmva_cmd_t cmd;
  fmva_sts_t sts;

  fmva_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fmva_dp #(
    .NUM_VOICES            (NUM_VOICES),
    .NUM_CHANNELS          (NUM_CHANNELS),
    .MAX_NOTES_PER_CHANNEL (MAX_NOTES_PER_CHANNEL),
    .AGE_BITS              (AGE_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .func_i           (in_i.func),
    .midi_channel_i   (in_i.midi_channel),
    .key_or_program_i (in_i.key_or_program),
    .value_i          (in_i.value),
    .elapsed_ms_i     (in_i.elapsed_ms),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .action_o         (out_o.action),
    .voice_o          (out_o.voice),
    .instrument_o     (out_o.instrument),
    .note_key_o       (out_o.note_key),
    .level_o          (out_o.level),
    .last_o           (out_o.last)
  );

  // Checks
  `FMVA_ASSERT_NXT(a_busy_after_beat, clk_i, rst_ni, in_i.valid && in_i.ready, !in_i.ready, "event taken while busy")
  `FMVA_ASSERT_IMP(a_emit_room, clk_i, rst_ni, (cmd.op == CMD_RELEASE) || (cmd.op == CMD_KEYON) || (cmd.op == CMD_LEVEL), sts.out_free, "result overwrites a pending beat")
  `FMVA_ASSERT_IMP(a_keyon_free_voice, clk_i, rst_ni, cmd.op == CMD_KEYON, !sts.cur_busy, "key-on onto a busy voice")

endmodule
